### rtl/core/plp_pkg.sv
`default_nettype none
package plp_pkg;
  // fixed normal format, signed Q1.30
  localparam int NORM_WIDTH = 32;
  localparam int NORM_FRAC = 30;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_WIDTH = 3;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_NORMAL_X = 3'd0,
    CFG_NORMAL_Y = 3'd1,
    CFG_NORMAL_Z = 3'd2,
    CFG_PLANE_OFFSET = 3'd3,
    CFG_PARALLEL_THRESHOLD = 3'd4
  } cfg_idx_t;

  localparam logic [NORM_WIDTH-1:0] NORMAL_Z_RESET = NORM_WIDTH'(1) << NORM_FRAC;
endpackage
`default_nettype wire

### rtl/core/plp_req_if.sv
`default_nettype none
interface plp_req_if #(
  parameter int COORD_WIDTH = plp_pkg::COORD_WIDTH_DEF
);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] origin_x;
  logic signed [COORD_WIDTH-1:0] origin_y;
  logic signed [COORD_WIDTH-1:0] origin_z;
  logic signed [COORD_WIDTH-1:0] dir_x;
  logic signed [COORD_WIDTH-1:0] dir_y;
  logic signed [COORD_WIDTH-1:0] dir_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                output ready);
endinterface
`default_nettype wire

### rtl/core/plp_res_if.sv
`default_nettype none
interface plp_res_if #(
  parameter int COORD_WIDTH = plp_pkg::COORD_WIDTH_DEF
);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] signed_dist;
  logic positive_side;
  logic is_parallel;
  logic hit;
  logic signed [COORD_WIDTH-1:0] enter_dist;

  modport source (output valid, signed_dist, positive_side, is_parallel, hit, enter_dist,
                  input ready);
  modport sink (input valid, signed_dist, positive_side, is_parallel, hit, enter_dist,
                output ready);
endinterface
`default_nettype wire

### rtl/core/plp_dot.sv
`default_nettype none
module plp_dot #(
  parameter int COORD_WIDTH = plp_pkg::COORD_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic signed [COORD_WIDTH-1:0] a [3],
  input  wire logic signed [plp_pkg::NORM_WIDTH-1:0] n [3],
  output logic signed [COORD_WIDTH+3:0] dot
);
  localparam int PW = COORD_WIDTH + plp_pkg::NORM_WIDTH;
  localparam int SUMW = PW + 2;
  localparam int DW = COORD_WIDTH + 4;
  localparam logic signed [SUMW-1:0] RND = SUMW'(1) << (plp_pkg::NORM_FRAC - 1);

  logic signed [PW-1:0] prod [3];
  logic signed [SUMW-1:0] sum;

  // stage 1: three products, registered
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        prod[k] <= PW'(a[k]) * PW'(n[k]);
      end
    end
  end

  // stage 2: exact sum, round half up to signed Q19.16 at default widths
  assign sum = SUMW'(prod[0]) + SUMW'(prod[1]) + SUMW'(prod[2]) + RND;

  always_ff @(posedge clk) begin
    if (en) begin
      dot <= DW'(sum >>> plp_pkg::NORM_FRAC);
    end
  end
endmodule
`default_nettype wire

### rtl/core/plp_cell.sv
`default_nettype none
module plp_cell #(
  parameter int MW = 36,
  parameter int QW = 53,
  parameter int SBW = 35
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic v_in,
  input  wire logic [MW-1:0] rem_in,
  input  wire logic [QW-1:0] num_in,
  input  wire logic [QW-1:0] quot_in,
  input  wire logic [MW-1:0] den_in,
  input  wire logic [SBW-1:0] sb_in,
  output logic v_out,
  output logic [MW-1:0] rem_out,
  output logic [QW-1:0] num_out,
  output logic [QW-1:0] quot_out,
  output logic [MW-1:0] den_out,
  output logic [SBW-1:0] sb_out
);
  logic [MW:0] trial;
  logic [MW:0] diff;
  logic ge;

  // one restoring step: bring down the next numerator bit, try subtract
  assign trial = {rem_in, num_in[QW-1]};
  assign diff = trial - {1'b0, den_in};
  assign ge = trial >= {1'b0, den_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? diff[MW-1:0] : trial[MW-1:0];
      num_out <= {num_in[QW-2:0], 1'b0};
      quot_out <= {quot_in[QW-2:0], ge};
      den_out <= den_in;
      sb_out <= sb_in;
    end
  end
endmodule
`default_nettype wire

### rtl/core/plane_point_distance_and_ray_hit_top.sv
// Pipeline: two product/sum stages, one distance stage, one divider cell per quotient bit,
//   one output stage. Throughput: one request per cycle unless a result is stalled;
// the divider is a chain of cells, one quotient bit each.
// A stalled result holds the whole pipeline until it is taken.
// Reset (synchronous, active high) empties the pipeline and loads register defaults.
`default_nettype none
module plane_point_distance_and_ray_hit_top #(
  parameter int COORD_WIDTH = plp_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS = plp_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [plp_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire logic [((COORD_WIDTH > plp_pkg::NORM_WIDTH) ? COORD_WIDTH
                      : plp_pkg::NORM_WIDTH)-1:0] cfg_data,
  plp_req_if.sink req,
  plp_res_if.source res
);
  localparam int NW = plp_pkg::NORM_WIDTH;
  localparam int DW = COORD_WIDTH + 4;
  localparam int SWD = DW + 1;
  localparam int MW = DW;
  localparam int QW = SWD + FRAC_BITS;
  localparam int TW = FRAC_BITS + 1;
  localparam int SBW = COORD_WIDTH + 3;

  logic en;
  logic signed [NW-1:0] normal_x, normal_y, normal_z;
  logic signed [COORD_WIDTH-1:0] plane_offset;
  logic [TW-1:0] parallel_threshold;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_x <= '0;
      normal_y <= '0;
      normal_z <= plp_pkg::NORMAL_Z_RESET;
      plane_offset <= '0;
      parallel_threshold <= TW'(1);
    end else if (cfg_we) begin
      unique case (plp_pkg::cfg_idx_t'(cfg_index))
        plp_pkg::CFG_NORMAL_X: normal_x <= cfg_data[NW-1:0];
        plp_pkg::CFG_NORMAL_Y: normal_y <= cfg_data[NW-1:0];
        plp_pkg::CFG_NORMAL_Z: normal_z <= cfg_data[NW-1:0];
        plp_pkg::CFG_PLANE_OFFSET: plane_offset <= cfg_data[COORD_WIDTH-1:0];
        plp_pkg::CFG_PARALLEL_THRESHOLD: parallel_threshold <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // global advance: pipeline moves unless a finished result is stalled
  assign en = !res.valid || res.ready;
  assign req.ready = en;

  logic signed [COORD_WIDTH-1:0] org [3];
  logic signed [COORD_WIDTH-1:0] dir [3];
  logic signed [NW-1:0] nrm [3];
  logic signed [DW-1:0] dot_o, dot_d;
  logic v1, v2, v3;

  assign org[0] = req.origin_x;
  assign org[1] = req.origin_y;
  assign org[2] = req.origin_z;
  assign dir[0] = req.dir_x;
  assign dir[1] = req.dir_y;
  assign dir[2] = req.dir_z;
  assign nrm[0] = normal_x;
  assign nrm[1] = normal_y;
  assign nrm[2] = normal_z;

  plp_dot #(.COORD_WIDTH(COORD_WIDTH)) u_dot_o (
    .clk(clk), .en(en), .a(org), .n(nrm), .dot(dot_o)
  );
  plp_dot #(.COORD_WIDTH(COORD_WIDTH)) u_dot_d (
    .clk(clk), .en(en), .a(dir), .n(nrm), .dot(dot_d)
  );

  // saturate a signed quotient-width value to the coordinate range
  function automatic logic [COORD_WIDTH-1:0] sat_c(input logic signed [QW:0] v);
    logic signed [QW:0] up;
    up = v >>> (COORD_WIDTH - 1);
    if (up == '0 || up == '1) begin
      sat_c = v[COORD_WIDTH-1:0];
    end else if (v[QW]) begin
      sat_c = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      sat_c = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
  endfunction

  // stage 3: distance, parallel test, divider operands
  logic signed [SWD-1:0] s_full;
  logic [MW-1:0] mag;
  logic [SWD-1:0] nmag;
  logic vneg, nneg, par, pos;
  logic [MW-1:0] den3;
  logic [QW-1:0] num3;
  logic [SBW-1:0] sb3;

  assign s_full = SWD'(dot_o) + SWD'(plane_offset);
  assign vneg = dot_d[DW-1];
  assign mag = vneg ? MW'(-dot_d) : MW'(dot_d);
  assign pos = (s_full > 0);
  assign nneg = pos;
  assign nmag = s_full[SWD-1] ? SWD'(-s_full) : SWD'(s_full);
  assign par = (mag < MW'(parallel_threshold)) || (mag == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= req.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den3 <= mag;
      num3 <= {nmag, {FRAC_BITS{1'b0}}};
      sb3 <= {sat_c((QW+1)'(s_full)), pos, par, nneg ^ vneg};
    end
  end

  // divider: chain of cells, one quotient bit per cell
  logic cv [QW+1];
  logic [MW-1:0] crem [QW+1];
  logic [QW-1:0] cnum [QW+1];
  logic [QW-1:0] cquot [QW+1];
  logic [MW-1:0] cden [QW+1];
  logic [SBW-1:0] csb [QW+1];

  assign cv[0] = v3;
  assign crem[0] = '0;
  assign cnum[0] = num3;
  assign cquot[0] = '0;
  assign cden[0] = den3;
  assign csb[0] = sb3;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    plp_cell #(.MW(MW), .QW(QW), .SBW(SBW)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .v_in(cv[i]), .rem_in(crem[i]), .num_in(cnum[i]), .quot_in(cquot[i]),
      .den_in(cden[i]), .sb_in(csb[i]),
      .v_out(cv[i+1]), .rem_out(crem[i+1]), .num_out(cnum[i+1]),
      .quot_out(cquot[i+1]), .den_out(cden[i+1]), .sb_out(csb[i+1])
    );
  end

  // output stage: apply sign, saturate, flags
  logic [QW-1:0] quot_f;
  logic [SBW-1:0] sb_f;
  logic sgn_f, par_f;
  logic signed [QW:0] q_signed;

  assign quot_f = cquot[QW];
  assign sb_f = csb[QW];
  assign sgn_f = sb_f[0];
  assign par_f = sb_f[1];
  assign q_signed = sgn_f ? -$signed({1'b0, quot_f}) : $signed({1'b0, quot_f});

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res.valid <= cv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.signed_dist <= sb_f[SBW-1:3];
      res.positive_side <= sb_f[2];
      res.is_parallel <= par_f;
      res.hit <= !par_f && !sgn_f && (quot_f != '0);
      res.enter_dist <= par_f ? '0 : sat_c(q_signed);
    end
  end
endmodule
`default_nettype wire

### rtl/core/plp_checker.sv
`default_nettype none
module plp_checker #(
  parameter int COORD_WIDTH = plp_pkg::COORD_WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic res_valid,
  input wire logic res_ready,
  input wire logic signed [COORD_WIDTH-1:0] signed_dist,
  input wire logic positive_side,
  input wire logic is_parallel,
  input wire logic hit,
  input wire logic signed [COORD_WIDTH-1:0] enter_dist
);
  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // a stalled result stays up
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // parallel rays never hit and report zero entry distance
  a_parallel: assert property (@(posedge clk) disable iff (rst)
    res_valid && is_parallel |-> !hit && enter_dist == '0)
    else $error("parallel result with hit or distance");

  // a hit has a positive entry distance
  a_hit: assert property (@(posedge clk) disable iff (rst)
    res_valid && hit |-> enter_dist > 0)
    else $error("hit with nonpositive distance");

  // positive side agrees with distance sign
  a_side: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> positive_side == (signed_dist > 0))
    else $error("side flag disagrees with distance");
endmodule

bind plane_point_distance_and_ray_hit_top plp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_plp_checker (
  .clk(clk),
  .rst(rst),
  .res_valid(res.valid),
  .res_ready(res.ready),
  .signed_dist(res.signed_dist),
  .positive_side(res.positive_side),
  .is_parallel(res.is_parallel),
  .hit(res.hit),
  .enter_dist(res.enter_dist)
);
`default_nettype wire
